/* rtl/butterworth3_lowpass_iir_top_macros.svh */
// Assertion macros used by the checker file of the third-order lowpass filter.
`ifndef BUTTERWORTH3_LOWPASS_IIR_TOP_MACROS_SVH
`define BUTTERWORTH3_LOWPASS_IIR_TOP_MACROS_SVH

// Concurrent assertion, checked outside reset.
`define BW3LP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent assertion, also checked while reset is applied.
`define BW3LP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/bw3lp_pkg.sv */
// Types and constants of the third-order lowpass IIR filter.
package bw3lp_pkg;

  localparam int SAMPLE_W     = 24;
  localparam int CHAN_W       = 3;
  localparam int COEF_W       = 32;
  localparam int FRAC_BITS    = 27;
  localparam int CFG_IDX_W    = 3;
  localparam int NUM_COEFS    = 5;
  localparam int CHANNELS_DEF = 8;

  // Pre-added sample pair, one product, and the accumulator.
  localparam int SUM_W  = SAMPLE_W + 1;
  localparam int PROD_W = COEF_W + SUM_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int YW_W   = ACC_W - FRAC_BITS;

  // Coefficient register indexes on the write port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A0,
    REG_A1,
    REG_B1,
    REG_B2,
    REG_B3
  } cfg_reg_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  // One channel's history: past inputs and past outputs, newest first.
  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t x3;
    sample_t y1;
    sample_t y2;
    sample_t y3;
  } hist_t;

endpackage

/* rtl/butterworth3_lowpass_iir_top.sv */
// Multichannel third-order lowpass IIR filter, direct form I, history held in one memory.
// Each accepted request flows through the numbered pipeline stages to the output register.
// Throughput: one request per cycle across channels while no output stall holds the pipeline; a
// request for a channel that is still in flight waits for its write-back.
// Reset clears the coefficients, the pipeline and the per-channel valid bits at once.
module butterworth3_lowpass_iir_top #(
  parameter int CHANNELS = bw3lp_pkg::CHANNELS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [bw3lp_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [bw3lp_pkg::COEF_W-1:0]           cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [bw3lp_pkg::SAMPLE_W-1:0]  sample_in_i,
  input  logic [bw3lp_pkg::CHAN_W-1:0]           chan_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [bw3lp_pkg::SAMPLE_W-1:0]  sample_out_o,
  output logic [bw3lp_pkg::CHAN_W-1:0]           chan_out_o
);
  import bw3lp_pkg::*;

  localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NSTG = 5;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [YW_W-1:0]  Y_MAX    = YW_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [YW_W-1:0]  Y_MIN    = -YW_W'(1 << (SAMPLE_W - 1));

  // Coefficient registers.
  coef_t coef_a0_q, coef_a1_q, coef_b1_q, coef_b2_q, coef_b3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a0_q <= '0;
      coef_a1_q <= '0;
      coef_b1_q <= '0;
      coef_b2_q <= '0;
      coef_b3_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_A0:  coef_a0_q <= cfg_wdata_i;
        REG_A1:  coef_a1_q <= cfg_wdata_i;
        REG_B1:  coef_b1_q <= cfg_wdata_i;
        REG_B2:  coef_b2_q <= cfg_wdata_i;
        REG_B3:  coef_b3_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Channel number folded into the history depth.
  logic [CHAN_W-1:0] chan_rem;
  logic [CW-1:0]     idx_in;

  always_comb begin
    chan_rem = chan_i;
    for (int k = 0; k < (1 << CHAN_W) - 1; k++) begin
      if (int'(chan_rem) >= CHANNELS) begin
        chan_rem = chan_rem - CHAN_W'(CHANNELS);
      end
    end
    idx_in = CW'(chan_rem);
  end

  // Pipeline control: valid, entry index and raw channel of every stage.
  logic              vld_q  [NSTG];
  logic [CW-1:0]     idx_q  [NSTG];
  logic [CHAN_W-1:0] chan_q [NSTG];
  logic              rdy    [NSTG];
  logic              in_vld [NSTG];
  logic [CW-1:0]     in_idx [NSTG];
  logic [CHAN_W-1:0] in_chan[NSTG];
  logic              out_vld_q;
  logic              out_room;
  logic              hazard;
  logic              accept;

  assign out_room = !out_vld_q || !out_stall_i;

  always_comb begin
    rdy[NSTG-1] = !vld_q[NSTG-1] || out_room;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  // A channel still in flight has not written its history back yet.
  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < NSTG; k++) begin
      if (vld_q[k] && (idx_q[k] == idx_in)) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_stall_o = !rdy[0] || hazard;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld[0]  = accept;
    in_idx[0]  = idx_in;
    in_chan[0] = chan_i;
    for (int k = 1; k < NSTG; k++) begin
      in_vld[k]  = vld_q[k-1];
      in_idx[k]  = idx_q[k-1];
      in_chan[k] = chan_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSTG; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= in_vld[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NSTG; k++) begin
      if (rdy[k] && in_vld[k]) begin
        idx_q[k]  <= in_idx[k];
        chan_q[k] <= in_chan[k];
      end
    end
  end

  // History memory with one read port and one write port, plus per-entry valid bits.
  hist_t          mem_q [CHANNELS];
  logic [CHANNELS-1:0] ent_vld_q;
  hist_t          rd_data_q;
  logic           rd_vld_q;
  hist_t          wr_data;
  logic           wr_en;

  assign wr_en = vld_q[NSTG-1] && out_room;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_data_q <= mem_q[idx_in];
    end
    if (wr_en) begin
      mem_q[idx_q[NSTG-1]] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (accept) begin
        rd_vld_q <= ent_vld_q[idx_in];
      end
      if (wr_en) begin
        ent_vld_q[idx_q[NSTG-1]] <= 1'b1;
      end
    end
  end

  // Stage 1: new sample waits beside the memory read.
  sample_t x1_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x1_q <= sample_in_i;
    end
  end

  // Stage 2: pre-add the symmetric input pairs and build the shifted history.
  hist_t                   rd_hist;
  hist_t                   nh2_d;
  hist_t                   nh2_q, nh3_q, nh4_q, nh5_q;
  logic signed [SUM_W-1:0] sx_q, s12_q;
  sample_t                 y1_2_q, y2_2_q, y3_2_q;

  assign rd_hist = rd_vld_q ? rd_data_q : '0;

  always_comb begin
    nh2_d    = '0;
    nh2_d.x1 = x1_q;
    nh2_d.x2 = rd_hist.x1;
    nh2_d.x3 = rd_hist.x2;
    nh2_d.y2 = rd_hist.y1;
    nh2_d.y3 = rd_hist.y2;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1] && in_vld[1]) begin
      sx_q   <= SUM_W'(x1_q) + SUM_W'(rd_hist.x3);
      s12_q  <= SUM_W'(rd_hist.x1) + SUM_W'(rd_hist.x2);
      y1_2_q <= rd_hist.y1;
      y2_2_q <= rd_hist.y2;
      y3_2_q <= rd_hist.y3;
      nh2_q  <= nh2_d;
    end
  end

  // Stage 3: five products in parallel.
  logic signed [PROD_W-1:0] p0_q, p1_q, p2_q, p3_q, p4_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2] && in_vld[2]) begin
      p0_q  <= coef_a0_q * sx_q;
      p1_q  <= coef_a1_q * s12_q;
      p2_q  <= coef_b1_q * y1_2_q;
      p3_q  <= coef_b2_q * y2_2_q;
      p4_q  <= coef_b3_q * y3_2_q;
      nh3_q <= nh2_q;
    end
  end

  // Stage 4: feedforward and feedback partial sums.
  logic signed [ACC_W-1:0] ff_q, fb_q, fb3_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3] && in_vld[3]) begin
      ff_q  <= ACC_W'(p0_q) + ACC_W'(p1_q);
      fb_q  <= ACC_W'(p2_q) + ACC_W'(p3_q);
      fb3_q <= ACC_W'(p4_q);
      nh4_q <= nh3_q;
    end
  end

  // Stage 5: full sum with the rounding half added.
  logic signed [ACC_W-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4] && in_vld[4]) begin
      acc_q <= ff_q - fb_q - fb3_q + RND_HALF;
      nh5_q <= nh4_q;
    end
  end

  // Drop the fraction (floor) and clamp to the sample range.
  logic signed [YW_W-1:0] y_wide;
  sample_t                y_sat;

  always_comb begin
    y_wide = $signed(acc_q[ACC_W-1:FRAC_BITS]);
    if (y_wide > Y_MAX) begin
      y_sat = sample_t'(Y_MAX);
    end else if (y_wide < Y_MIN) begin
      y_sat = sample_t'(Y_MIN);
    end else begin
      y_sat = sample_t'(y_wide);
    end
    wr_data    = nh5_q;
    wr_data.y1 = y_sat;
  end

  // Output register.
  sample_t           sample_out_q;
  logic [CHAN_W-1:0] chan_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_room) begin
      out_vld_q <= vld_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sample_out_q <= y_sat;
      chan_out_q   <= chan_q[NSTG-1];
    end
  end

  assign out_valid_o  = out_vld_q;
  assign sample_out_o = sample_out_q;
  assign chan_out_o   = chan_out_q;

endmodule

/* rtl/bw3lp_checker.sv */
// Port-level checker for the third-order lowpass filter, bound to the top level.
`include "butterworth3_lowpass_iir_top_macros.svh"

module bw3lp_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   cfg_we_i,
  input logic [bw3lp_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input logic [bw3lp_pkg::COEF_W-1:0]           cfg_wdata_i,
  input logic                                   in_valid_i,
  input logic                                   in_stall_o,
  input logic signed [bw3lp_pkg::SAMPLE_W-1:0]  sample_in_i,
  input logic [bw3lp_pkg::CHAN_W-1:0]           chan_i,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic signed [bw3lp_pkg::SAMPLE_W-1:0]  sample_out_o,
  input logic [bw3lp_pkg::CHAN_W-1:0]           chan_out_o
);
  import bw3lp_pkg::*;

  logic                         in_acc;
  logic                         in_wait;
  logic                         out_wait;
  logic                         chan_rep;
  logic                         cfg_idle;
  logic [SAMPLE_W+CHAN_W-1:0]   in_bits;
  logic [SAMPLE_W+CHAN_W-1:0]   out_bits;
  logic [CFG_IDX_W+COEF_W-1:0]  cfg_bits;
  logic [CHAN_W-1:0]            chan_prev_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_wait  = in_valid_i && in_stall_o;
  assign out_wait = out_valid_o && out_stall_i;
  assign in_bits  = {sample_in_i, chan_i};
  assign out_bits = {sample_out_o, chan_out_o};
  assign cfg_bits = {cfg_idx_i, cfg_wdata_i};
  assign cfg_idle = !in_valid_i && !out_valid_o && !$isunknown(cfg_bits);

  // Channel offered in the previous cycle, to spot a repeat.
  always_ff @(posedge clk_i) begin
    chan_prev_q <= chan_i;
  end

  assign chan_rep = in_valid_i && (chan_i == chan_prev_q);

  // A stalled result keeps its valid and its payload.
  `BW3LP_ASSERT(a_out_hold, out_wait |=> out_valid_o && $stable(out_bits), "stalled result moved")

  // No result is shown in the cycle after reset is seen.
  `BW3LP_ASSERT_RST(a_rst_quiet, !rst_ni |=> !out_valid_o, "result valid after reset")

  // A second request for the channel just accepted must wait for its history.
  `BW3LP_ASSERT(a_chan_wait, in_acc ##1 chan_rep |-> in_stall_o, "channel reused in flight")

  // A stalled request keeps its valid and its payload.
  `BW3LP_ASSERT(a_in_hold, in_wait |=> in_valid_i && $stable(in_bits), "stalled request moved")

  // Coefficients are written only with the filter idle.
  `BW3LP_ASSERT(a_cfg_idle, cfg_we_i |-> cfg_idle, "coefficient write while busy")

endmodule

bind butterworth3_lowpass_iir_top bw3lp_checker u_bw3lp_checker (.*);

/* sim/butterworth3_lowpass_iir_top_tb.sv */
// Self-checking testbench for the multichannel third-order lowpass IIR filter.
`timescale 1ns / 100ps

module butterworth3_lowpass_iir_top_tb;
  import bw3lp_pkg::*;

  localparam int CH             = CHANNELS_DEF;
  localparam int N_DIRECTED     = 34;
  localparam int ITEMS_PER_SET  = 170;
  localparam int STUCK_LIMIT    = 4000;
  localparam int SETTLE_CYCLES  = 16;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Coefficient values in Q4.27.
  localparam coef_t COEF_ONE  = 32'sd134217728;
  localparam coef_t COEF_HALF = 32'sd67108864;
  localparam coef_t COEF_MAX  = 32'sh7FFF_FFFF;
  localparam coef_t COEF_MIN  = 32'sh8000_0000;
  localparam coef_t COEF_ZERO = 32'sd0;

  // Butterworth at a quarter of the sample rate: (1 + 3z^-1 + 3z^-2 + z^-3) / 6 over 1 + z^-2 / 3.
  localparam coef_t HB_A0 = 32'sd22369621;
  localparam coef_t HB_A1 = 32'sd67108864;
  localparam coef_t HB_B2 = 32'sd44739243;

  // Three real poles at 0.5 with unity gain at DC.
  localparam coef_t TP_A  = 32'sd4194304;
  localparam coef_t TP_B1 = -32'sd201326592;
  localparam coef_t TP_B2 = 32'sd100663296;
  localparam coef_t TP_B3 = -32'sd16777216;

  // Write indexes past the coefficient list; the block ignores them.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_FIRST = CFG_IDX_W'(NUM_COEFS);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LAST  = {CFG_IDX_W{1'b1}};

  typedef enum int {
    SET_HALFBAND,
    SET_TRIPLE_POLE,
    SET_RANDOM_SMALL,
    SET_RANDOM_FULL,
    SET_ALL_MAX,
    SET_ALL_MIN
  } coef_set_e;

  typedef struct packed {
    sample_t             sample;
    logic [CHAN_W-1:0]   chan;
  } filtered_t;

  typedef struct packed {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [COEF_W-1:0]    value;
    sample_t              sample;
    logic [CHAN_W-1:0]    chan;
    bit                   typed;
    sample_t              want;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [COEF_W-1:0]    cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  sample_t              sample_in_i;
  logic [CHAN_W-1:0]    chan_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  sample_t              sample_out_o;
  logic [CHAN_W-1:0]    chan_out_o;

  // Expected filter outputs, oldest first.
  filtered_t filtered_q[$];
  filtered_t oldest;

  // Predictor state: coefficients and per-channel histories, newest first.
  longint  coef_now [NUM_COEFS];
  sample_t hist_x1 [CH];
  sample_t hist_x2 [CH];
  sample_t hist_x3 [CH];
  sample_t hist_y1 [CH];
  sample_t hist_y2 [CH];
  sample_t hist_y3 [CH];

  coef_t             set_coefs [NUM_COEFS];
  dir_row_t          directed_rows [N_DIRECTED];
  bit                sender_burst;
  logic [CHAN_W-1:0] last_chan;
  int                error_count;
  int                stuck_cycles;

  butterworth3_lowpass_iir_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .chan_i       (chan_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .chan_out_o   (chan_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // One filter step: direct form I with rounding half up and saturation to 24 bits.
  function automatic sample_t filter_sample(input sample_t x, input logic [CHAN_W-1:0] ch);
    int      c;
    longint  acc;
    longint  rounded;
    sample_t y;
    c = int'(ch) % CH;
    acc = coef_now[REG_A0] * (longint'(x) + longint'(hist_x3[c]))
        + coef_now[REG_A1] * (longint'(hist_x1[c]) + longint'(hist_x2[c]))
        - coef_now[REG_B1] * longint'(hist_y1[c])
        - coef_now[REG_B2] * longint'(hist_y2[c])
        - coef_now[REG_B3] * longint'(hist_y3[c]);
    rounded = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (rounded > longint'(SAMPLE_MAX)) begin
      y = SAMPLE_MAX;
    end else if (rounded < longint'(SAMPLE_MIN)) begin
      y = SAMPLE_MIN;
    end else begin
      y = sample_t'(rounded);
    end
    // The clamped output is what enters the feedback history.
    hist_x3[c] = hist_x2[c];
    hist_x2[c] = hist_x1[c];
    hist_x1[c] = x;
    hist_y3[c] = hist_y2[c];
    hist_y2[c] = hist_y1[c];
    hist_y1[c] = y;
    return y;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [COEF_W-1:0] value);
    return '{1'b1, idx, value, '0, '0, 1'b0, '0};
  endfunction

  function automatic dir_row_t req_row(input sample_t s, input logic [CHAN_W-1:0] ch);
    return '{1'b0, '0, '0, s, ch, 1'b0, '0};
  endfunction

  function automatic dir_row_t chk_row(input sample_t s, input logic [CHAN_W-1:0] ch,
                                       input sample_t want);
    return '{1'b0, '0, '0, s, ch, 1'b1, want};
  endfunction

  // Mostly short gaps between requests, a few long ones, none in a burst.
  function automatic int next_gap();
    int r;
    if (sender_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t random_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return sample_t'($urandom);
    if (r < 70) return sample_t'(int'($urandom_range(0, 2000)) - 1000);
    if (r < 80) return SAMPLE_MAX;
    if (r < 90) return SAMPLE_MIN;
    return '0;
  endfunction

  // Repeating a channel now and then puts back-to-back requests on one history.
  function automatic logic [CHAN_W-1:0] pick_chan();
    if ($urandom_range(0, 9) >= 3) begin
      last_chan = CHAN_W'($urandom_range(0, (1 << CHAN_W) - 1));
    end
    return last_chan;
  endfunction

  // Hold off new requests until every expected output has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (filtered_q.size() != 0);
  endtask

  // Coefficient writes happen only with the filter idle.
  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    if (idx < NUM_COEFS) coef_now[idx] = longint'(coef_t'(value));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Send one request; on acceptance the predicted output is queued.
  task automatic push_sample(input sample_t s, input logic [CHAN_W-1:0] ch,
                             input bit typed, input sample_t want);
    int        gap;
    sample_t   y;
    filtered_t e;
    gap = next_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= s;
    chan_i      <= ch;
    do @(posedge clk_i); while (in_stall_o);
    y = filter_sample(s, ch);
    e.sample = typed ? want : y;
    e.chan   = ch;
    filtered_q.push_back(e);
    @(negedge clk_i);
  endtask

  // Output stall: long free-running stretches, short stalls, and now and then a long one.
  initial begin : stall_gen
    int r;
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall_i <= 1'b0;
        n = $urandom_range(1, 30);
      end else if (r < 92) begin
        out_stall_i <= 1'b1;
        n = $urandom_range(1, 3);
      end else begin
        out_stall_i <= 1'b1;
        n = $urandom_range(8, 40);
      end
      repeat (n - 1) @(negedge clk_i);
    end
  end

  // Compare each accepted output with the oldest expectation; watch for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (filtered_q.size() == 0) begin
          error_count++;
          $display("%0t: output with no request pending: sample_out %0d, chan_out %0d",
                   $time, sample_out_o, chan_out_o);
        end else begin
          oldest = filtered_q.pop_front();
          if (sample_out_o !== oldest.sample) begin
            error_count++;
            $display("%0t: sample_out expected %0d, actual %0d (chan %0d)",
                     $time, oldest.sample, sample_out_o, oldest.chan);
          end
          if (chan_out_o !== oldest.chan) begin
            error_count++;
            $display("%0t: chan_out expected %0d, actual %0d",
                     $time, oldest.chan, chan_out_o);
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  initial begin : main
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    sample_in_i  = '0;
    chan_i       = '0;
    sender_burst = 1'b0;
    last_chan    = '0;
    error_count  = 0;
    stuck_cycles = 0;
    foreach (coef_now[i]) coef_now[i] = 0;
    foreach (hist_x1[c]) begin
      hist_x1[c] = '0;
      hist_x2[c] = '0;
      hist_x3[c] = '0;
      hist_y1[c] = '0;
      hist_y2[c] = '0;
      hist_y3[c] = '0;
    end

    // Directed rows: zero gain after reset, unit and extreme gains, rounding, then a real filter.
    directed_rows = '{
      chk_row(SAMPLE_MAX, 0, '0),
      chk_row(SAMPLE_MIN, 7, '0),
      cfg_row(REG_A0, COEF_ONE),
      cfg_row(CFG_IDX_SPARE_FIRST, 32'hFFFF_FFFF),
      cfg_row(CFG_IDX_SPARE_LAST, 32'h8000_0000),
      chk_row(24'sd1000, 1, 24'sd1000),
      chk_row(-24'sd1, 2, -24'sd1),
      req_row(24'sd5, 1),
      req_row(24'sd7, 1),
      chk_row('0, 1, 24'sd1000),
      cfg_row(REG_A0, COEF_MAX),
      chk_row(24'sd1, 3, 24'sd16),
      chk_row(SAMPLE_MAX, 4, SAMPLE_MAX),
      chk_row(SAMPLE_MIN, 5, SAMPLE_MIN),
      cfg_row(REG_A0, COEF_MIN),
      chk_row(SAMPLE_MAX, 6, SAMPLE_MIN),
      chk_row(SAMPLE_MIN, 6, SAMPLE_MAX),
      cfg_row(REG_A0, COEF_HALF),
      chk_row(24'sd1, 0, 24'sd1),
      chk_row(-24'sd1, 7, '0),
      chk_row(24'sd3, 3, 24'sd2),
      chk_row(-24'sd3, 4, -24'sd1),
      cfg_row(REG_A0, HB_A0),
      cfg_row(REG_A1, HB_A1),
      cfg_row(REG_B1, COEF_ZERO),
      cfg_row(REG_B2, HB_B2),
      cfg_row(REG_B3, COEF_ZERO),
      req_row(24'sd4194304, 2),
      req_row('0, 2),
      req_row('0, 2),
      req_row('0, 2),
      req_row(SAMPLE_MAX, 5),
      req_row(SAMPLE_MAX, 5),
      req_row(SAMPLE_MAX, 5)
    };

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        write_coef(directed_rows[r].idx, directed_rows[r].value);
      end else begin
        push_sample(directed_rows[r].sample, directed_rows[r].chan,
                    directed_rows[r].typed, directed_rows[r].want);
      end
    end

    // Random requests under a series of coefficient sets, extremes last.
    for (int s = 0; s <= int'(SET_ALL_MIN); s++) begin
      case (coef_set_e'(s))
        SET_HALFBAND:    set_coefs = '{HB_A0, HB_A1, COEF_ZERO, HB_B2, COEF_ZERO};
        SET_TRIPLE_POLE: set_coefs = '{TP_A, TP_A, TP_B1, TP_B2, TP_B3};
        SET_RANDOM_SMALL: begin
          foreach (set_coefs[i]) begin
            set_coefs[i] = coef_t'(int'($urandom_range(0, 1 << 26)) - (1 << 25));
          end
        end
        SET_RANDOM_FULL: begin
          foreach (set_coefs[i]) set_coefs[i] = coef_t'($urandom);
        end
        SET_ALL_MAX: begin
          foreach (set_coefs[i]) set_coefs[i] = COEF_MAX;
        end
        default: begin
          foreach (set_coefs[i]) set_coefs[i] = COEF_MIN;
        end
      endcase
      for (int i = 0; i < NUM_COEFS; i++) begin
        write_coef(CFG_IDX_W'(i), set_coefs[i]);
      end
      for (int k = 0; k < ITEMS_PER_SET; k++) begin
        if (k % 64 == 0) sender_burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) == 0) drain_results();
        push_sample(random_sample(), pick_chan(), 1'b0, '0);
      end
    end

    // Wait for the last outputs, then a little longer to catch any extra one.
    in_valid_i <= 1'b0;
    while (filtered_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
